@@ sv/tmpu_pkg.sv @@
// Shared types, codes and helpers for the tagged memory protection unit.
package tmpu_pkg;

	localparam int MEMORY_BYTES_DEF = 65536;
	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int TAG_POSITION_DEF = 56;

	localparam int MEMORY_BYTES_MAX = 16777216;
	localparam int PAGE_BYTES_MIN   = 64;
	localparam int WIDX_MAX_W       = $clog2(MEMORY_BYTES_MAX / 8);
	localparam int PIDX_MAX_W       = $clog2(MEMORY_BYTES_MAX / PAGE_BYTES_MIN);

	localparam int QUEUE_DEPTH = 2;

	localparam int RIGHT_READ  = 0;
	localparam int RIGHT_WRITE = 1;
	localparam int RIGHT_EXEC  = 2;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_TLOAD   = 3'd1,
		OP_PSTORE  = 3'd2,
		OP_TSTORE  = 3'd3,
		OP_FETCH   = 3'd4,
		OP_SETPERM = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		FC_NONE           = 4'd0,
		FC_FETCH_MISALIGN = 4'd1,
		FC_FETCH_ACCESS   = 4'd2,
		FC_LOAD_MISALIGN  = 4'd3,
		FC_LOAD_ACCESS    = 4'd4,
		FC_STORE_MISALIGN = 4'd5,
		FC_STORE_ACCESS   = 4'd6,
		FC_LOAD_TAG       = 4'd7,
		FC_STORE_TAG      = 4'd8,
		FC_WX_VIOLATION   = 4'd9
	} fault_t;

	typedef struct packed {
		op_t                   op;
		fault_t                early;
		logic [63:0]           address;
		logic [7:0]            ptag;
		logic [63:0]           wdata;
		logic [7:0]            wtag;
		logic [2:0]            perm;
		logic                  page_in;
		logic [PIDX_MAX_W-1:0] pidx;
		logic [WIDX_MAX_W-1:0] widx;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_access(op_t op);
		return op inside {OP_LOAD, OP_TLOAD, OP_PSTORE, OP_TSTORE, OP_FETCH};
	endfunction

	function automatic fault_t access_fault(op_t op);
		fault_t f;
		unique case (op) inside
			OP_FETCH:             f = FC_FETCH_ACCESS;
			OP_PSTORE, OP_TSTORE: f = FC_STORE_ACCESS;
			default:              f = FC_LOAD_ACCESS;
		endcase
		return f;
	endfunction

	function automatic fault_t misalign_fault(op_t op);
		fault_t f;
		unique case (op) inside
			OP_FETCH:             f = FC_FETCH_MISALIGN;
			OP_PSTORE, OP_TSTORE: f = FC_STORE_MISALIGN;
			default:              f = FC_LOAD_MISALIGN;
		endcase
		return f;
	endfunction

	function automatic logic [2:0] need_right(op_t op);
		logic [2:0] m;
		m = '0;
		unique case (op) inside
			OP_FETCH:             m[RIGHT_EXEC]  = 1'b1;
			OP_PSTORE, OP_TSTORE: m[RIGHT_WRITE] = 1'b1;
			default:              m[RIGHT_READ]  = 1'b1;
		endcase
		return m;
	endfunction

endpackage

@@ sv/tmpu_queue.sv @@
// Short item queue between the classifying front and the executing back.
module tmpu_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tmpu_pkg::entry_t    push_entry,
	input  logic                pop,
	output tmpu_pkg::entry_t    head,
	output tmpu_pkg::q_status_t status
);

	localparam int DEPTH = tmpu_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	tmpu_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

@@ sv/tmpu_front.sv @@
// Front end: accept items, check bounds and alignment, find word and page.
module tmpu_front #(
	parameter int MEMORY_BYTES = tmpu_pkg::MEMORY_BYTES_DEF,
	parameter int PAGE_BYTES   = tmpu_pkg::PAGE_BYTES_DEF,
	parameter int TAG_POSITION = tmpu_pkg::TAG_POSITION_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          operation,
	input  logic [63:0]         address,
	input  logic [63:0]         pointer,
	input  logic [63:0]         write_data,
	input  logic [7:0]          write_tag,
	input  logic [15:0]         page_number,
	input  logic [2:0]          permission_bits,
	input  logic                clearing,
	input  tmpu_pkg::q_status_t q_status,
	output logic                push,
	output tmpu_pkg::entry_t    push_entry
);

	localparam int AW         = $clog2(MEMORY_BYTES);
	localparam int PL         = $clog2(PAGE_BYTES);
	localparam int RW         = AW + 2;
	localparam int PW         = 2 * AW + 2;
	localparam int WORD_COUNT = MEMORY_BYTES / 8;
	localparam int PAGE_COUNT = MEMORY_BYTES / PAGE_BYTES;
	localparam logic [63:0] VALUE_MASK = 64'((65'd1 << TAG_POSITION) - 65'd1);
	localparam logic [RW-1:0] RECIP = RW'(((64'd1 << (AW + PL)) + 64'(PAGE_BYTES) - 64'd1)
		/ 64'(PAGE_BYTES));

	tmpu_pkg::op_t    op;
	tmpu_pkg::fault_t early;
	tmpu_pkg::entry_t in_entry;
	tmpu_pkg::entry_t s1_entry_s1;
	logic             s1_valid_s1;
	logic             accept;
	logic             in_bounds;
	logic             misaligned;
	logic [7:0]       ptag;
	logic [31:0]      widx_raw;
	logic [31:0]      widx;
	logic             set_in;
	logic [PW-1:0]    product;
	logic [31:0]      page;
	logic             page_in;

	assign op         = tmpu_pkg::op_t'(operation);
	assign in_bounds  = address < 64'(MEMORY_BYTES);
	assign misaligned = (op == tmpu_pkg::OP_FETCH) ? (address[1:0] != '0)
		: (address[2:0] != '0);
	assign ptag       = pointer[TAG_POSITION +: 8];
	assign widx_raw   = 32'(address[AW-1:3]);
	assign widx       = (widx_raw >= 32'(WORD_COUNT)) ? widx_raw - 32'(WORD_COUNT) : widx_raw;
	assign set_in     = 32'(page_number) < 32'(PAGE_COUNT);

	always_comb begin
		early = tmpu_pkg::FC_NONE;
		if (tmpu_pkg::is_access(op)) begin
			if (!in_bounds) begin
				early = tmpu_pkg::access_fault(op);
			end else if (misaligned) begin
				early = tmpu_pkg::misalign_fault(op);
			end
		end
	end

	always_comb begin
		in_entry         = '0;
		in_entry.op      = op;
		in_entry.early   = early;
		in_entry.address = address;
		in_entry.ptag    = ptag;
		in_entry.wdata   = (op == tmpu_pkg::OP_TSTORE) ? (write_data & VALUE_MASK) : write_data;
		in_entry.wtag    = (op == tmpu_pkg::OP_TSTORE) ? write_tag : ptag;
		in_entry.perm    = permission_bits;
		in_entry.page_in = set_in;
		in_entry.pidx    = set_in ? tmpu_pkg::PIDX_MAX_W'(32'(page_number)) : '0;
		in_entry.widx    = tmpu_pkg::WIDX_MAX_W'(widx);
	end

	assign push     = s1_valid_s1 && !q_status.full;
	assign in_stall = clearing || (s1_valid_s1 && q_status.full);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (push) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_entry_s1 <= in_entry;
		end
	end

	// page = address / PAGE_BYTES by reciprocal multiply, exact for in-bounds addresses
	assign product = PW'(s1_entry_s1.address[AW-1:0]) * PW'(RECIP);
	assign page    = 32'(product >> (AW + PL));
	assign page_in = page < 32'(PAGE_COUNT);

	always_comb begin
		push_entry = s1_entry_s1;
		if (s1_entry_s1.op != tmpu_pkg::OP_SETPERM) begin
			push_entry.page_in = page_in;
			push_entry.pidx    = page_in ? tmpu_pkg::PIDX_MAX_W'(page) : '0;
		end
	end

endmodule

@@ sv/tmpu_back.sv @@
// Back end: word, tag and page-rights stores, final checks and results.
module tmpu_back #(
	parameter int MEMORY_BYTES = tmpu_pkg::MEMORY_BYTES_DEF,
	parameter int PAGE_BYTES   = tmpu_pkg::PAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tmpu_pkg::q_status_t q_status,
	input  tmpu_pkg::entry_t    head,
	output logic                pop,
	output logic                clearing,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          fault_code,
	output logic [63:0]         fault_address,
	output logic [63:0]         read_data,
	output logic [7:0]          read_tag,
	output logic                set_accepted
);

	localparam int WORD_COUNT = MEMORY_BYTES / 8;
	localparam int WD_W       = $clog2(WORD_COUNT);
	localparam int PAGE_COUNT = MEMORY_BYTES / PAGE_BYTES;
	localparam int PG_DEPTH   = (PAGE_COUNT > 0) ? PAGE_COUNT : 1;
	localparam int PG_W       = (PG_DEPTH > 1) ? $clog2(PG_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t           state_q;
	logic [WD_W-1:0]  clr_q;
	tmpu_pkg::entry_t ent_q;

	logic [63:0]      word_mem [WORD_COUNT];
	logic [7:0]       tag_mem  [WORD_COUNT];
	logic [2:0]       pr_mem   [PG_DEPTH];
	logic [63:0]      word_rd_q;
	logic [7:0]       tag_rd_q;
	logic [2:0]       pr_rd_q;

	tmpu_pkg::fault_t code;
	logic [2:0]       rights;
	logic             is_store;
	logic             ok;
	logic             fire;
	logic             mem_we;
	logic [WD_W-1:0]  mem_wa;
	logic [63:0]      mem_wd;
	logic [7:0]       tag_wd;
	logic             pr_we;
	logic [PG_W-1:0]  pr_wa;
	logic [2:0]       pr_wd;
	logic             clr_pg;
	logic [63:0]      rdata;
	logic [7:0]       rtag;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign fire     = (state_q == ST_EXEC) && (!out_valid || !out_stall);
	assign rights   = ent_q.page_in ? pr_rd_q : '0;
	assign is_store = (ent_q.op == tmpu_pkg::OP_PSTORE) || (ent_q.op == tmpu_pkg::OP_TSTORE);

	always_comb begin
		code = tmpu_pkg::FC_NONE;
		if (tmpu_pkg::is_access(ent_q.op)) begin
			if (ent_q.early != tmpu_pkg::FC_NONE) begin
				code = ent_q.early;
			end else if (rights[tmpu_pkg::RIGHT_WRITE] && rights[tmpu_pkg::RIGHT_EXEC]) begin
				code = tmpu_pkg::FC_WX_VIOLATION;
			end else if ((rights & tmpu_pkg::need_right(ent_q.op)) == '0) begin
				code = tmpu_pkg::access_fault(ent_q.op);
			end else if (ent_q.op != tmpu_pkg::OP_FETCH && tag_rd_q != '0
				&& tag_rd_q != ent_q.ptag) begin
				code = is_store ? tmpu_pkg::FC_STORE_TAG : tmpu_pkg::FC_LOAD_TAG;
			end
		end
	end

	assign ok = tmpu_pkg::is_access(ent_q.op) && (code == tmpu_pkg::FC_NONE);

	always_comb begin
		rdata = '0;
		rtag  = '0;
		if (ok) begin
			case (ent_q.op)
				tmpu_pkg::OP_LOAD: begin
					rdata = word_rd_q;
				end
				tmpu_pkg::OP_TLOAD: begin
					rdata = word_rd_q;
					rtag  = tag_rd_q;
				end
				tmpu_pkg::OP_FETCH: begin
					rdata = ent_q.address[2] ? {32'd0, word_rd_q[63:32]}
						: {32'd0, word_rd_q[31:0]};
				end
				default: begin
					rdata = '0;
				end
			endcase
		end
	end

	assign clr_pg = 32'(clr_q) < 32'(PG_DEPTH);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ent_q.widx[WD_W-1:0];
		mem_wd = ent_q.wdata;
		tag_wd = ent_q.wtag;
		pr_we  = 1'b0;
		pr_wa  = ent_q.pidx[PG_W-1:0];
		pr_wd  = ent_q.perm;
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
			tag_wd = '0;
			pr_we  = clr_pg;
			pr_wa  = PG_W'(clr_q);
			pr_wd  = '0;
		end else if (fire) begin
			mem_we = ok && is_store;
			pr_we  = (ent_q.op == tmpu_pkg::OP_SETPERM) && ent_q.page_in;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_rd_q <= word_mem[head.widx[WD_W-1:0]];
			tag_rd_q  <= tag_mem[head.widx[WD_W-1:0]];
			pr_rd_q   <= pr_mem[head.pidx[PG_W-1:0]];
		end
		if (mem_we) begin
			word_mem[mem_wa] <= mem_wd;
			tag_mem[mem_wa]  <= tag_wd;
		end
		if (pr_we) begin
			pr_mem[pr_wa] <= pr_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			out_valid     <= 1'b0;
			fault_code    <= '0;
			fault_address <= '0;
			read_data     <= '0;
			read_tag      <= '0;
			set_accepted  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !fire) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WD_W'(WORD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						out_valid     <= 1'b1;
						fault_code    <= code;
						fault_address <= (code != tmpu_pkg::FC_NONE) ? ent_q.address : '0;
						read_data     <= rdata;
						read_tag      <= rtag;
						set_accepted  <= (ent_q.op == tmpu_pkg::OP_SETPERM) && ent_q.page_in;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/tagged_memory_protection_unit.sv @@
// Tagged memory protection unit top level: front end, item queue and back end.
//
// After reset the block sweeps all MEMORY_BYTES/8 words (8192 at the defaults) of
// its word and tag stores, one word a cycle, clears the page-rights store too
// and holds in_stall high until the sweep is done. While in_stall is low the
// front end takes one item a cycle, checks bounds and alignment and works out
// the word and page, then hands the item on through a two-entry queue. The back
// end handles an item in two steps: ST_IDLE pops it and reads the single-port
// word, tag and page-rights stores, and ST_EXEC checks, writes and registers
// the result; it pops no new item until that result is registered. A finished
// result waits in the output register while further items are accepted.
module tagged_memory_protection_unit #(
	parameter int MEMORY_BYTES = tmpu_pkg::MEMORY_BYTES_DEF,
	parameter int PAGE_BYTES   = tmpu_pkg::PAGE_BYTES_DEF,
	parameter int TAG_POSITION = tmpu_pkg::TAG_POSITION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [63:0] address,
	input  logic [63:0] pointer,
	input  logic [63:0] write_data,
	input  logic [7:0]  write_tag,
	input  logic [15:0] page_number,
	input  logic [2:0]  permission_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  fault_code,
	output logic [63:0] fault_address,
	output logic [63:0] read_data,
	output logic [7:0]  read_tag,
	output logic        set_accepted
);

	tmpu_pkg::q_status_t q_status;
	tmpu_pkg::entry_t    push_entry;
	tmpu_pkg::entry_t    head;
	logic                push;
	logic                pop;
	logic                clearing;

	tmpu_front #(
		.MEMORY_BYTES (MEMORY_BYTES),
		.PAGE_BYTES   (PAGE_BYTES),
		.TAG_POSITION (TAG_POSITION)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.address         (address),
		.pointer         (pointer),
		.write_data      (write_data),
		.write_tag       (write_tag),
		.page_number     (page_number),
		.permission_bits (permission_bits),
		.clearing        (clearing),
		.q_status        (q_status),
		.push            (push),
		.push_entry      (push_entry)
	);

	tmpu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	tmpu_back #(
		.MEMORY_BYTES (MEMORY_BYTES),
		.PAGE_BYTES   (PAGE_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head          (head),
		.pop           (pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fault_code    (fault_code),
		.fault_address (fault_address),
		.read_data     (read_data),
		.read_tag      (read_tag),
		.set_accepted  (set_accepted)
	);

	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> in_stall)
		else $error("item accepted during the store sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code != tmpu_pkg::FC_NONE) |-> (read_data == '0) && (read_tag == '0))
		else $error("faulting item returned data");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_code == tmpu_pkg::FC_NONE) |-> (fault_address == '0))
		else $error("fault address set without a fault");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_accepted |-> (fault_code == tmpu_pkg::FC_NONE) && (read_data == '0))
		else $error("permission set result carries access fields");

	assert property (@(posedge clk) disable iff (!arst_n) q_status.full |-> !q_status.empty)
		else $error("queue status inconsistent");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the tagged memory protection unit: directed and random traffic.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_SIZE   = tmpu_pkg::MEMORY_BYTES_DEF;
	localparam int PAGE_SIZE  = tmpu_pkg::PAGE_BYTES_DEF;
	localparam int TAG_LSB    = tmpu_pkg::TAG_POSITION_DEF;
	localparam int WORD_COUNT = MEM_SIZE / 8;
	localparam int PAGE_COUNT = MEM_SIZE / PAGE_SIZE;
	localparam int IDLE_LIMIT = 50000;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam logic [2:0] PERM_OFF  = 3'b000;
	localparam logic [2:0] PERM_R    = 3'b001;
	localparam logic [2:0] PERM_RW   = 3'b011;
	localparam logic [2:0] PERM_X    = 3'b100;
	localparam logic [2:0] PERM_WX   = 3'b110;
	localparam logic [2:0] PERM_RWX  = 3'b111;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] addr;
		logic [63:0] ptr;
		logic [63:0] wdata;
		logic [7:0]  wtag;
		logic [15:0] pnum;
		logic [2:0]  perm;
	} mpu_item_t;

	typedef struct packed {
		logic [3:0]  fault;
		logic [63:0] faddr;
		logic [63:0] rdata;
		logic [7:0]  rtag;
		logic        accepted;
	} mpu_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  operation = '0;
	logic [63:0] address = '0;
	logic [63:0] pointer = '0;
	logic [63:0] write_data = '0;
	logic [7:0]  write_tag = '0;
	logic [15:0] page_number = '0;
	logic [2:0]  permission_bits = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  fault_code;
	logic [63:0] fault_address;
	logic [63:0] read_data;
	logic [7:0]  read_tag;
	logic        set_accepted;

	logic [63:0] shadow_words [WORD_COUNT];
	logic [7:0]  shadow_tags [WORD_COUNT];
	logic [2:0]  shadow_rights [PAGE_COUNT];

	mpu_result_t expected_results [$];
	int          error_count = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          run_left = 0;
	bit          steady = 1'b0;

	tagged_memory_protection_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.address         (address),
		.pointer         (pointer),
		.write_data      (write_data),
		.write_tag       (write_tag),
		.page_number     (page_number),
		.permission_bits (permission_bits),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.fault_code      (fault_code),
		.fault_address   (fault_address),
		.read_data       (read_data),
		.read_tag        (read_tag),
		.set_accepted    (set_accepted)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		else if (r < 94)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_tag();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'h5A;
			2: return 8'hA5;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic mpu_item_t make_item(logic [2:0] op, logic [63:0] addr, logic [7:0] tag,
			logic [63:0] wdata, logic [7:0] wtag, logic [15:0] pnum, logic [2:0] perm);
		mpu_item_t it;
		it.op    = op;
		it.addr  = addr;
		it.ptr   = {tag, 56'h0123_4567_89AB_CD};
		it.wdata = wdata;
		it.wtag  = wtag;
		it.pnum  = pnum;
		it.perm  = perm;
		return it;
	endfunction

	function automatic mpu_result_t predict_access(mpu_item_t it);
		mpu_result_t      res;
		tmpu_pkg::fault_t fc;
		tmpu_pkg::fault_t acc_fc;
		tmpu_pkg::fault_t mis_fc;
		logic [2:0]       need;
		logic [2:0]       rights;
		logic [7:0]       ptag;
		logic [63:0]      word;
		int unsigned      widx;
		bit               fetch;
		bit               store;
		bit               misaligned;
		res   = '0;
		ptag  = it.ptr[TAG_LSB +: 8];
		widx  = int'((it.addr >> 3) % WORD_COUNT);
		fetch = (it.op == tmpu_pkg::OP_FETCH);
		store = (it.op == tmpu_pkg::OP_PSTORE) || (it.op == tmpu_pkg::OP_TSTORE);
		case (it.op) inside
			tmpu_pkg::OP_LOAD, tmpu_pkg::OP_TLOAD, tmpu_pkg::OP_PSTORE, tmpu_pkg::OP_TSTORE,
			tmpu_pkg::OP_FETCH: begin
				if (fetch) begin
					acc_fc = tmpu_pkg::FC_FETCH_ACCESS;
					mis_fc = tmpu_pkg::FC_FETCH_MISALIGN;
					need   = 3'b1 << tmpu_pkg::RIGHT_EXEC;
				end else if (store) begin
					acc_fc = tmpu_pkg::FC_STORE_ACCESS;
					mis_fc = tmpu_pkg::FC_STORE_MISALIGN;
					need   = 3'b1 << tmpu_pkg::RIGHT_WRITE;
				end else begin
					acc_fc = tmpu_pkg::FC_LOAD_ACCESS;
					mis_fc = tmpu_pkg::FC_LOAD_MISALIGN;
					need   = 3'b1 << tmpu_pkg::RIGHT_READ;
				end
				misaligned = fetch ? (it.addr[1:0] != 2'b00) : (it.addr[2:0] != 3'b000);
				rights = (it.addr < MEM_SIZE) ? shadow_rights[it.addr[31:0] / PAGE_SIZE] : PERM_OFF;
				if (it.addr >= MEM_SIZE)
					fc = acc_fc;
				else if (misaligned)
					fc = mis_fc;
				else if (rights[tmpu_pkg::RIGHT_WRITE] && rights[tmpu_pkg::RIGHT_EXEC])
					fc = tmpu_pkg::FC_WX_VIOLATION;
				else if ((rights & need) == 3'b000)
					fc = acc_fc;
				else if (!fetch && shadow_tags[widx] != 8'h00 && shadow_tags[widx] != ptag)
					fc = store ? tmpu_pkg::FC_STORE_TAG : tmpu_pkg::FC_LOAD_TAG;
				else
					fc = tmpu_pkg::FC_NONE;
				word = shadow_words[widx];
				if (fc != tmpu_pkg::FC_NONE) begin
					res.fault = fc;
					res.faddr = it.addr;
				end else begin
					case (it.op)
						tmpu_pkg::OP_LOAD: res.rdata = word;
						tmpu_pkg::OP_TLOAD: begin
							res.rdata = word;
							res.rtag  = shadow_tags[widx];
						end
						tmpu_pkg::OP_PSTORE: begin
							shadow_words[widx] = it.wdata;
							shadow_tags[widx]  = ptag;
						end
						tmpu_pkg::OP_TSTORE: begin
							shadow_words[widx] = it.wdata & ((64'd1 << TAG_LSB) - 64'd1);
							shadow_tags[widx]  = it.wtag;
						end
						default: res.rdata = it.addr[2] ? {32'h0, word[63:32]} : {32'h0, word[31:0]};
					endcase
				end
			end
			tmpu_pkg::OP_SETPERM: begin
				if (it.pnum < PAGE_COUNT) begin
					shadow_rights[it.pnum] = it.perm;
					res.accepted = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic mpu_item_t random_item();
		mpu_item_t it;
		int          r;
		logic [63:0] hot;
		r = $urandom_range(0, 99);
		if (r < 12)
			it.op = tmpu_pkg::OP_SETPERM;
		else if (r < 13)
			it.op = OP_SPARE_A;
		else if (r < 14)
			it.op = OP_SPARE_B;
		else
			it.op = 3'($urandom_range(0, 4));
		hot = 64'($urandom_range(0, PAGE_COUNT - 1)) * PAGE_SIZE + 64'($urandom_range(0, 7)) * 8;
		r = $urandom_range(0, 99);
		if (r < 70)
			it.addr = hot;
		else if (r < 85)
			it.addr = 64'($urandom_range(0, MEM_SIZE - 1));
		else if (r < 95)
			it.addr = hot + 64'd4;
		else
			it.addr = {$urandom, $urandom};
		it.ptr   = {pick_tag(), 24'($urandom), 32'($urandom)};
		it.wdata = {$urandom, $urandom};
		it.wtag  = pick_tag();
		if ($urandom_range(0, 99) < 85)
			it.pnum = 16'($urandom_range(0, PAGE_COUNT - 1));
		else
			it.pnum = 16'($urandom_range(0, 65535));
		it.perm = 3'($urandom_range(0, 7));
		if (it.perm[tmpu_pkg::RIGHT_WRITE] && it.perm[tmpu_pkg::RIGHT_EXEC]
			&& $urandom_range(0, 1) == 1)
			it.perm = PERM_RW;
		return it;
	endfunction

	task automatic send_item(input mpu_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= it.op;
		address         <= it.addr;
		pointer         <= it.ptr;
		write_data      <= it.wdata;
		write_tag       <= it.wtag;
		page_number     <= it.pnum;
		permission_bits <= it.perm;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_results.push_back(predict_access(it));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic test_reset_state();
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'h0, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'h0, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(OP_SPARE_A, 64'h8, 8'hFF, '1, 8'hFF, 16'h1, PERM_RWX));
		send_item(make_item(OP_SPARE_B, '1, 8'hFF, '1, 8'hFF, '1, PERM_RWX));
		wait_for_results();
	endtask

	task automatic test_rights_and_faults();
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'(PAGE_COUNT),
			PERM_RW));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'hFFFF, PERM_RWX));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'd0, PERM_RW));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'd1, PERM_WX));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'd15, PERM_RWX));
		send_item(make_item(tmpu_pkg::OP_PSTORE, 64'h8, 8'hA5, '1, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_TLOAD, 64'h8, 8'hA5, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'h8, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_PSTORE, 64'h8, 8'h11, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_TSTORE, 64'h8, 8'hA5, 64'hFEDC_BA98_7654_3210, 8'hFF,
			16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_TLOAD, 64'h8, 8'hFF, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'h4, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_PSTORE, 64'h1, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'(MEM_SIZE), 8'h00, 64'h0, 8'h00, 16'h0,
			PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'hFFFF_FFFF_FFFF_FFFC, 8'h00, 64'h0, 8'h00,
			16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'(PAGE_SIZE), 8'h00, 64'h0, 8'h00, 16'h0,
			PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'(15 * PAGE_SIZE), 8'h00, 64'h0, 8'h00, 16'h0,
			PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'd4, PERM_RW));
		send_item(make_item(tmpu_pkg::OP_PSTORE, 64'(4 * PAGE_SIZE), 8'h00,
			64'h8765_4321_DEAD_BEEF, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_SETPERM, 64'h0, 8'h00, 64'h0, 8'h00, 16'd4, PERM_X));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'(4 * PAGE_SIZE), 8'h00, 64'h0, 8'h00, 16'h0,
			PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'(4 * PAGE_SIZE + 4), 8'h00, 64'h0, 8'h00,
			16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'(4 * PAGE_SIZE + 2), 8'h00, 64'h0, 8'h00,
			16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_FETCH, 64'h0, 8'h00, 64'h0, 8'h00, 16'h0, PERM_OFF));
		send_item(make_item(tmpu_pkg::OP_LOAD, 64'(PAGE_SIZE * 2), 8'h00, 64'h0, 8'h00, 16'h0,
			PERM_OFF));
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		repeat (150) send_item(random_item());
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < 820; n++) begin
			if (n == 300 || n == 600)
				wait_for_results();
			send_item(random_item());
		end
	endtask

	// drive out_stall
	always @(posedge clk) begin
		if (steady) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
			out_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			run_left   = $urandom_range(0, 12);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		mpu_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none expected", read_data, 64'h0);
			end else begin
				want = expected_results.pop_front();
				if (fault_code !== want.fault)
					report_mismatch("fault_code", 64'(fault_code), 64'(want.fault));
				if (fault_address !== want.faddr)
					report_mismatch("fault_address", fault_address, want.faddr);
				if (read_data !== want.rdata)
					report_mismatch("read_data", read_data, want.rdata);
				if (read_tag !== want.rtag)
					report_mismatch("read_tag", 64'(read_tag), 64'(want.rtag));
				if (set_accepted !== want.accepted)
					report_mismatch("set_accepted", 64'(set_accepted), 64'(want.accepted));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WORD_COUNT; i++) begin
			shadow_words[i] = '0;
			shadow_tags[i]  = '0;
		end
		for (int i = 0; i < PAGE_COUNT; i++)
			shadow_rights[i] = PERM_OFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_rights_and_faults();
		test_back_to_back();
		test_random_traffic();
		wait_for_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
